@@ rtl/hrti_pkg.sv @@
// ----------------------------------------------------------------------------
// hrti_pkg
// Shared types, constants and tables for the heading/rate trajectory
// integrator: configuration layout, command/status bundles, CORDIC tables.
// ----------------------------------------------------------------------------
package hrti_pkg;

   // CORDIC iteration count and derived widths
   localparam int TRIG_ITERATIONS = 16;
   localparam int ITER_W          = $clog2(TRIG_ITERATIONS);
   localparam int ATAN_LEN        = 30;
   localparam int ATAN_IDX_W      = $clog2(ATAN_LEN);

   // Gain-compensated CORDIC start value, Q1.30
   localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
   // Eighth of a turn, rounds heading to the nearest quadrant
   localparam logic [31:0] QUAD_HALF = 32'h2000_0000;

   // atan(2^-i) in binary-angle units (2^32 = one turn)
   localparam logic signed [31:0] ATAN_TABLE [ATAN_LEN] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5,
      32'sd3,         32'sd1
   };

   // Register map
   localparam int CSR_INDEX_W = 8;
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_X       = 8'd0,
      REG_START_Y       = 8'd1,
      REG_START_HEADING = 8'd2,
      REG_BODY_VEL_X    = 8'd3,
      REG_BODY_VEL_Y    = 8'd4,
      REG_YAW_RATE      = 8'd5,
      REG_TIME_STEP     = 8'd6,
      REG_STEP_COUNT    = 8'd7
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic        [31:0] start_heading;
      logic signed [31:0] body_vel_x;
      logic signed [31:0] body_vel_y;
      logic signed [31:0] yaw_rate;
      logic        [23:0] time_step;
      logic        [15:0] step_count;
   } cfg_type;

   // Quadrant the heading was folded from
   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   // Operations of the shared multiplier
   typedef enum logic [2:0] {
      MUL_C_VX,
      MUL_S_VY,
      MUL_S_VX,
      MUL_C_VY,
      MUL_WX_DT,
      MUL_WY_DT,
      MUL_YAW_DT
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ROTATE,
      ST_QUAD,
      ST_MUL,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic              restart;
      logic              trig_init;
      logic              trig_step;
      logic [ITER_W-1:0] trig_iter;
      logic              quad_fix;
      logic              mul_en;
      mul_op_type        mul_op;
      logic              emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic done;
      logic rsp_free;
   } status_type;

endpackage

@@ rtl/hrti_csr.sv @@
// ----------------------------------------------------------------------------
// hrti_csr
// Configuration register file; writes beyond the register map are dropped.
// ----------------------------------------------------------------------------
module hrti_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hrti_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   output hrti_pkg::cfg_type                cfg
);

   hrti_pkg::cfg_type cfg_ff;
   hrti_pkg::cfg_type cfg_in;

   // always able to take a write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hrti_pkg::REG_START_X:       cfg_in.start_x       = csr_wdata;
            hrti_pkg::REG_START_Y:       cfg_in.start_y       = csr_wdata;
            hrti_pkg::REG_START_HEADING: cfg_in.start_heading = csr_wdata;
            hrti_pkg::REG_BODY_VEL_X:    cfg_in.body_vel_x    = csr_wdata;
            hrti_pkg::REG_BODY_VEL_Y:    cfg_in.body_vel_y    = csr_wdata;
            hrti_pkg::REG_YAW_RATE:      cfg_in.yaw_rate      = csr_wdata;
            hrti_pkg::REG_TIME_STEP:     cfg_in.time_step     = csr_wdata[23:0];
            hrti_pkg::REG_STEP_COUNT:    cfg_in.step_count    = csr_wdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/hrti_ctrl.sv @@
// ----------------------------------------------------------------------------
// hrti_ctrl
// Sequencer: restart/check, CORDIC iterations, multiplier schedule, emit.
// ----------------------------------------------------------------------------
module hrti_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   input  hrti_pkg::status_type   status,
   output hrti_pkg::cmd_type      cmd
);

   localparam logic [hrti_pkg::ITER_W-1:0] ITER_LAST =
      hrti_pkg::ITER_W'(hrti_pkg::TRIG_ITERATIONS - 1);

   hrti_pkg::state_type          state_ff, state_in;
   logic [hrti_pkg::ITER_W-1:0]  iter_ff, iter_in;
   hrti_pkg::mul_op_type         op_ff, op_in;

   // next state and counters
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      op_in    = op_ff;
      case (state_ff)
         hrti_pkg::ST_IDLE: begin
            if (req_valid) state_in = hrti_pkg::ST_CHECK;
         end
         hrti_pkg::ST_CHECK: begin
            iter_in = '0;
            if (status.done) state_in = hrti_pkg::ST_IDLE;
            else             state_in = hrti_pkg::ST_ROTATE;
         end
         hrti_pkg::ST_ROTATE: begin
            iter_in = hrti_pkg::ITER_W'(iter_ff + 1'b1);
            if (iter_ff == ITER_LAST) state_in = hrti_pkg::ST_QUAD;
         end
         hrti_pkg::ST_QUAD: begin
            op_in    = hrti_pkg::MUL_C_VX;
            state_in = hrti_pkg::ST_MUL;
         end
         hrti_pkg::ST_MUL: begin
            case (op_ff)
               hrti_pkg::MUL_C_VX:  op_in = hrti_pkg::MUL_S_VY;
               hrti_pkg::MUL_S_VY:  op_in = hrti_pkg::MUL_S_VX;
               hrti_pkg::MUL_S_VX:  op_in = hrti_pkg::MUL_C_VY;
               hrti_pkg::MUL_C_VY:  op_in = hrti_pkg::MUL_WX_DT;
               hrti_pkg::MUL_WX_DT: op_in = hrti_pkg::MUL_WY_DT;
               hrti_pkg::MUL_WY_DT: op_in = hrti_pkg::MUL_YAW_DT;
               default: begin
                  op_in    = hrti_pkg::MUL_C_VX;
                  state_in = hrti_pkg::ST_DRAIN;
               end
            endcase
         end
         hrti_pkg::ST_DRAIN: begin
            state_in = hrti_pkg::ST_EMIT;
         end
         hrti_pkg::ST_EMIT: begin
            if (status.rsp_free) state_in = hrti_pkg::ST_IDLE;
         end
         default: state_in = hrti_pkg::ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      req_ready     = (state_ff == hrti_pkg::ST_IDLE);
      cmd.restart   = (state_ff == hrti_pkg::ST_IDLE) && req_valid && req_restart;
      cmd.trig_init = (state_ff == hrti_pkg::ST_CHECK) && !status.done;
      cmd.trig_step = (state_ff == hrti_pkg::ST_ROTATE);
      cmd.trig_iter = iter_ff;
      cmd.quad_fix  = (state_ff == hrti_pkg::ST_QUAD);
      cmd.mul_en    = (state_ff == hrti_pkg::ST_MUL);
      cmd.mul_op    = op_ff;
      cmd.emit      = (state_ff == hrti_pkg::ST_EMIT) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrti_pkg::ST_IDLE;
         iter_ff  <= '0;
         op_ff    <= hrti_pkg::MUL_C_VX;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         op_ff    <= op_in;
      end
   end

   // checks
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("emit while output register is occupied");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == hrti_pkg::ST_CHECK))
      else $error("accepted request did not go to check");

   a_rotate_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hrti_pkg::ST_ROTATE && iter_ff == ITER_LAST)
      |=> (state_ff == hrti_pkg::ST_QUAD))
      else $error("last CORDIC iteration did not go to quadrant fix");

endmodule

@@ rtl/hrti_dp.sv @@
// ----------------------------------------------------------------------------
// hrti_dp
// Datapath: pose state, CORDIC sine/cosine, shared 33x33 multiplier,
// velocity rotation with saturation, integration and output register.
// ----------------------------------------------------------------------------
module hrti_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  hrti_pkg::cmd_type    cmd,
   input  hrti_pkg::cfg_type    cfg,
   output hrti_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_point_index,
   output logic signed [31:0]   rsp_pos_x,
   output logic signed [31:0]   rsp_pos_y,
   output logic signed [31:0]   rsp_world_vel_x,
   output logic signed [31:0]   rsp_world_vel_y,
   output logic [31:0]          rsp_heading,
   output logic                 rsp_last_point
);

   // floor(v / 2^30), saturated to signed 32 bits
   function automatic logic [31:0] sat_q30(input logic signed [64:0] v);
      logic signed [64:0] r;
      r = v >>> 30;
      if ((&r[64:31]) || !(|r[64:31])) sat_q30 = r[31:0];
      else if (r[64])                  sat_q30 = 32'h8000_0000;
      else                             sat_q30 = 32'h7FFF_FFFF;
   endfunction

   // pose state
   logic [31:0]        cur_x_ff, cur_x_in;
   logic [31:0]        cur_y_ff, cur_y_in;
   logic [31:0]        cur_heading_ff, cur_heading_in;
   logic [15:0]        cur_index_ff, cur_index_in;

   // CORDIC
   hrti_pkg::quad_type quad_ff, quad_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;

   // multiplier and accumulation
   logic signed [63:0]   prod_ff, prod_in;
   logic                 prod_vld_ff, prod_vld_in;
   hrti_pkg::mul_op_type prod_op_ff, prod_op_in;
   logic signed [63:0]   acc_ff, acc_in;
   logic signed [31:0]   wx_ff, wx_in, wy_ff, wy_in;
   logic [31:0]          dx_ff, dx_in, dy_ff, dy_in, dh_ff, dh_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_index_ff, rsp_index_in;
   logic [31:0]          rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [31:0]          rsp_wx_ff, rsp_wx_in, rsp_wy_ff, rsp_wy_in;
   logic [31:0]          rsp_hd_ff, rsp_hd_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [31:0]          heading_round;
   logic signed [31:0]   atan_val;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   mul_full;
   logic signed [64:0]   acc_diff, acc_sum;

   assign status.done     = (cur_index_ff >= cfg.step_count);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign heading_round = cur_heading_ff + hrti_pkg::QUAD_HALF;
   assign atan_val      = hrti_pkg::ATAN_TABLE[hrti_pkg::ATAN_IDX_W'(cmd.trig_iter)];

   // pose: reload on restart, integrate on emit
   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      cur_heading_in = cur_heading_ff;
      cur_index_in   = cur_index_ff;
      if (cmd.restart) begin
         cur_x_in       = cfg.start_x;
         cur_y_in       = cfg.start_y;
         cur_heading_in = cfg.start_heading;
         cur_index_in   = '0;
      end else if (cmd.emit) begin
         cur_x_in       = cur_x_ff + dx_ff;
         cur_y_in       = cur_y_ff + dy_ff;
         cur_heading_in = cur_heading_ff + dh_ff;
         cur_index_in   = cur_index_ff + 16'd1;
      end
   end

   // CORDIC rotation and quadrant unfold
   always_comb begin
      quad_in = quad_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (cmd.trig_init) begin
         quad_in = hrti_pkg::quad_type'(heading_round[31:30]);
         cx_in   = hrti_pkg::CORDIC_X0;
         cy_in   = '0;
         cz_in   = cur_heading_ff - {heading_round[31:30], 30'b0};
      end else if (cmd.trig_step) begin
         if (!cz_ff[31]) begin
            cx_in = cx_ff - (cy_ff >>> cmd.trig_iter);
            cy_in = cy_ff + (cx_ff >>> cmd.trig_iter);
            cz_in = cz_ff - atan_val;
         end else begin
            cx_in = cx_ff + (cy_ff >>> cmd.trig_iter);
            cy_in = cy_ff - (cx_ff >>> cmd.trig_iter);
            cz_in = cz_ff + atan_val;
         end
      end
      if (cmd.quad_fix) begin
         case (quad_ff)
            hrti_pkg::QUAD_0:   begin cos_in = cx_ff;  sin_in = cy_ff;  end
            hrti_pkg::QUAD_90:  begin cos_in = -cy_ff; sin_in = cx_ff;  end
            hrti_pkg::QUAD_180: begin cos_in = -cx_ff; sin_in = -cy_ff; end
            default:            begin cos_in = cy_ff;  sin_in = -cx_ff; end
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_op)
         hrti_pkg::MUL_C_VX:  begin mul_a = 33'(cos_ff); mul_b = 33'(cfg.body_vel_x); end
         hrti_pkg::MUL_S_VY:  begin mul_a = 33'(sin_ff); mul_b = 33'(cfg.body_vel_y); end
         hrti_pkg::MUL_S_VX:  begin mul_a = 33'(sin_ff); mul_b = 33'(cfg.body_vel_x); end
         hrti_pkg::MUL_C_VY:  begin mul_a = 33'(cos_ff); mul_b = 33'(cfg.body_vel_y); end
         hrti_pkg::MUL_WX_DT: begin mul_a = 33'(wx_ff);  mul_b = {9'b0, cfg.time_step}; end
         hrti_pkg::MUL_WY_DT: begin mul_a = 33'(wy_ff);  mul_b = {9'b0, cfg.time_step}; end
         default: begin mul_a = 33'(cfg.yaw_rate); mul_b = {9'b0, cfg.time_step}; end
      endcase
   end

   assign mul_full    = mul_a * mul_b;
   assign prod_in     = mul_full[63:0];
   assign prod_vld_in = cmd.mul_en;
   assign prod_op_in  = cmd.mul_op;

   assign acc_diff = 65'(acc_ff) - 65'(prod_ff);
   assign acc_sum  = 65'(acc_ff) + 65'(prod_ff);

   // consume the registered product
   always_comb begin
      acc_in = acc_ff;
      wx_in  = wx_ff;
      wy_in  = wy_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      dh_in  = dh_ff;
      if (prod_vld_ff) begin
         case (prod_op_ff)
            hrti_pkg::MUL_C_VX:  acc_in = prod_ff;
            hrti_pkg::MUL_S_VY:  wx_in  = sat_q30(acc_diff);
            hrti_pkg::MUL_S_VX:  acc_in = prod_ff;
            hrti_pkg::MUL_C_VY:  wy_in  = sat_q30(acc_sum);
            hrti_pkg::MUL_WX_DT: dx_in  = prod_ff[55:24];
            hrti_pkg::MUL_WY_DT: dy_in  = prod_ff[55:24];
            default:             dh_in  = prod_ff[47:16];
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_wx_in    = rsp_wx_ff;
      rsp_wy_in    = rsp_wy_ff;
      rsp_hd_in    = rsp_hd_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = cur_index_ff;
         rsp_x_in     = cur_x_ff;
         rsp_y_in     = cur_y_ff;
         rsp_wx_in    = wx_ff;
         rsp_wy_in    = wy_ff;
         rsp_hd_in    = cur_heading_ff;
         rsp_last_in  = ({1'b0, cur_index_ff} + 17'd1) == {1'b0, cfg.step_count};
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         cur_heading_ff <= '0;
         cur_index_ff   <= '0;
         prod_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         cur_heading_ff <= cur_heading_in;
         cur_index_ff   <= cur_index_in;
         prod_vld_ff    <= prod_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quad_ff      <= quad_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      cos_ff       <= cos_in;
      sin_ff       <= sin_in;
      prod_ff      <= prod_in;
      prod_op_ff   <= prod_op_in;
      acc_ff       <= acc_in;
      wx_ff        <= wx_in;
      wy_ff        <= wy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dh_ff        <= dh_in;
      rsp_index_ff <= rsp_index_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_wx_ff    <= rsp_wx_in;
      rsp_wy_ff    <= rsp_wy_in;
      rsp_hd_ff    <= rsp_hd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_world_vel_x = rsp_wx_ff;
   assign rsp_world_vel_y = rsp_wy_ff;
   assign rsp_heading     = rsp_hd_ff;
   assign rsp_last_point  = rsp_last_ff;

   // checks
   a_restart_index: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> (cur_index_ff == 16'd0))
      else $error("restart did not clear the point index");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted point not presented");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready)
      |=> (rsp_valid_ff && $stable(rsp_index_ff) && $stable(rsp_x_ff)))
      else $error("stalled point changed before acceptance");

endmodule

@@ rtl/heading_rate_trajectory_integrator.sv @@
// ----------------------------------------------------------------------------
// heading_rate_trajectory_integrator
// Planar dead-reckoning: rotates body velocity by heading (CORDIC), emits
// one trajectory point per step up to the point count and integrates position and heading.
//
//   channel  prefix  direction  payload
//   request  req_    in         restart
//   response rsp_    out        point_index, pos_x/y, world_vel_x/y, heading,
//                               last_point
//   config   csr_    in         index (8 bits), wdata (32 bits)
//
// A step that emits runs through accept, check, TRIG_ITERATIONS CORDIC
// iterations, quadrant fix, seven passes through the shared multiplier, drain
// and emit. A step past the point count returns from check to idle.
// Reset clears pose, index, state, config and valid flags; no clearing pass.
// A stalled response holds the block in emit until the output register frees.
// ----------------------------------------------------------------------------
module heading_rate_trajectory_integrator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_point_index,
   output logic signed [31:0]               rsp_pos_x,
   output logic signed [31:0]               rsp_pos_y,
   output logic signed [31:0]               rsp_world_vel_x,
   output logic signed [31:0]               rsp_world_vel_y,
   output logic [31:0]                      rsp_heading,
   output logic                             rsp_last_point,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hrti_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);

   hrti_pkg::cfg_type    cfg;
   hrti_pkg::cmd_type    cmd;
   hrti_pkg::status_type status;

   // configuration registers
   hrti_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   hrti_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath
   hrti_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_world_vel_x (rsp_world_vel_x),
      .rsp_world_vel_y (rsp_world_vel_y),
      .rsp_heading     (rsp_heading),
      .rsp_last_point  (rsp_last_point)
   );

endmodule
